// ===== hw/rtl/huf_pkg.sv =====
// huf_pkg: shared types and constants for the huffman code bit packer
// used by huffman_code_bit_packer; no dependencies
`default_nettype none

package huf_pkg;

  // operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_e;

  localparam int MaxCodeLen = 32;
  localparam int CodeWidth  = 32;
  // longest length a table entry may hold
  localparam int CodeCap    = (MaxCodeLen < CodeWidth) ? MaxCodeLen : CodeWidth;

  localparam int NumSymbols = 256;
  localparam int SymW       = 8;
  localparam int LenW       = 6;
  localparam int PendW      = 7;
  localparam int CntW       = 3;
  localparam int AccW       = PendW + CodeWidth;
  localparam int EntryW     = LenW + CodeWidth;
  localparam int MaxBytes   = 4;
  localparam int RemW       = 3;

endpackage

`default_nettype wire

// ===== hw/rtl/huffman_code_bit_packer.sv =====
// huffman_code_bit_packer: input passes the table read and stage 1 registers, then the output
// register. one input transaction per cycle while each item yields at most one byte and the
// output is not stalled; an encode yielding n bytes holds the output register for n output
// transactions, one byte each. reset clears table valid bits, pending bits and all handshake
// state at once; no clearing pass, input ready right after reset. depends on huf_pkg, huf_ram.
`default_nettype none

module huffman_code_bit_packer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [7:0]  symbol_i,
  input  wire logic [31:0] code_bits_i,
  input  wire logic [5:0]  code_length_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       packed_byte_o,
  output logic [3:0]       valid_bits_o,
  output logic             last_o
);

  localparam int LenW   = huf_pkg::LenW;
  localparam int CodeW  = huf_pkg::CodeWidth;
  localparam int PendW  = huf_pkg::PendW;
  localparam int CntW   = huf_pkg::CntW;
  localparam int AccW   = huf_pkg::AccW;
  localparam int EntryW = huf_pkg::EntryW;
  localparam int RemW   = huf_pkg::RemW;

  logic in_acc;
  logic out_acc;
  logic is_load;

  // load entry preparation
  logic [LenW-1:0]   load_len;
  logic [CodeW-1:0]  load_code;
  logic [EntryW-1:0] rdata;

  // table valid bits
  logic [huf_pkg::NumSymbols-1:0] tvalid_q, tvalid_d;

  // stage 1
  logic            s1_valid_q;
  logic [1:0]      s1_op_q;
  logic            s1_hit_q;
  logic            s1_go;

  // pending bits
  logic [PendW-1:0] pbits_q, pbits_d;
  logic [CntW-1:0]  pcnt_q, pcnt_d;

  // emitter
  logic [CodeW-1:0] word_q, word_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [3:0]       vb_q, vb_d;
  logic             emit_free;

  // encode datapath
  logic [LenW-1:0]  len_eff;
  logic [CodeW-1:0] code_eff;
  logic [AccW-1:0]  acc;
  logic [AccW-1:0]  acc_sh;
  logic [LenW-1:0]  total;
  logic [RemW-1:0]  nbytes;
  logic [CntW-1:0]  newcnt;
  logic [5:0]       lsh;
  logic [7:0]       flush_byte;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign is_load = in_acc && (operation_i == huf_pkg::OP_LOAD);

  // saturate length and mask code bits above it
  always_comb begin
    if (code_length_i > LenW'(huf_pkg::CodeCap)) begin
      load_len = LenW'(huf_pkg::CodeCap);
    end else begin
      load_len = code_length_i;
    end
    load_code = code_bits_i & ~({CodeW{1'b1}} << load_len);
  end

  // code and length table, read on every accepted transaction
  huf_ram #(
    .Width(EntryW),
    .Depth(huf_pkg::NumSymbols)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (is_load),
    .waddr_i(symbol_i),
    .wdata_i({load_len, load_code}),
    .re_i   (in_acc),
    .raddr_i(symbol_i),
    .rdata_o(rdata)
  );

  always_comb begin
    tvalid_d = tvalid_q;
    if (is_load) begin
      tvalid_d[symbol_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvalid_q <= '0;
    end else begin
      tvalid_q <= tvalid_d;
    end
  end

  // stage 1 handshake
  assign emit_free  = (rem_q == '0) || ((rem_q == RemW'(1)) && out_ready_i);
  assign s1_go      = s1_valid_q && emit_free;
  assign in_ready_o = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q  <= operation_i;
      s1_hit_q <= tvalid_q[symbol_i];
    end
  end

  // append code behind pending bits
  always_comb begin
    len_eff    = s1_hit_q ? rdata[EntryW-1:CodeW] : '0;
    code_eff   = rdata[CodeW-1:0];
    acc        = ({{CodeW{1'b0}}, pbits_q} << len_eff) | {{PendW{1'b0}}, code_eff};
    total      = {{(LenW-CntW){1'b0}}, pcnt_q} + len_eff;
    nbytes     = total[LenW-1:CntW];
    newcnt     = total[CntW-1:0];
    acc_sh     = acc >> newcnt;
    lsh        = {RemW'(RemW'(huf_pkg::MaxBytes) - nbytes), 3'b000};
    flush_byte = {1'b0, pbits_q} << (4'd8 - {1'b0, pcnt_q});
  end

  // pending register and emitter load
  always_comb begin
    pbits_d = pbits_q;
    pcnt_d  = pcnt_q;
    word_d  = word_q;
    vb_d    = vb_q;
    rem_d   = rem_q;
    if (out_acc) begin
      word_d = word_q << 8;
      rem_d  = rem_q - RemW'(1);
    end
    if (s1_go) begin
      case (s1_op_q)
        huf_pkg::OP_ENCODE: begin
          if (len_eff != '0) begin
            pbits_d = acc[PendW-1:0] & ~({PendW{1'b1}} << newcnt);
            pcnt_d  = newcnt;
            if (nbytes != '0) begin
              word_d = acc_sh[CodeW-1:0] << lsh;
              rem_d  = nbytes;
              vb_d   = 4'd8;
            end
          end
        end
        huf_pkg::OP_FLUSH: begin
          if (pcnt_q != '0) begin
            word_d  = {flush_byte, {(CodeW-8){1'b0}}};
            rem_d   = RemW'(1);
            vb_d    = {1'b0, pcnt_q};
            pbits_d = '0;
            pcnt_d  = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pbits_q <= '0;
      pcnt_q  <= '0;
      rem_q   <= '0;
    end else begin
      pbits_q <= pbits_d;
      pcnt_q  <= pcnt_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    vb_q   <= vb_d;
  end

  // output register drives the result channel
  assign out_valid_o   = (rem_q != '0);
  assign packed_byte_o = word_q[CodeW-1:CodeW-8];
  assign valid_bits_o  = vb_q;
  assign last_o        = (rem_q == RemW'(1));

endmodule

`default_nettype wire

// ===== hw/rtl/huf_ram.sv =====
// huf_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module huf_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// testbench for huffman_code_bit_packer: directed and random load, encode and flush
// transactions, checked byte by byte against a bit-accurate packing predictor
// depends on huf_pkg and the huffman_code_bit_packer rtl
module testbench;

  // undefined operation, which the block must ignore
  localparam logic [1:0] OpUndef = 2'd3;
  localparam int WatchdogLimit = 3000;
  localparam int HoldCycles = 150;
  localparam int TailCycles = 20;

  typedef enum logic [1:0] {
    IDLE_TX_LIGHT,
    IDLE_TX_HEAVY,
    IDLE_NONE
  } idle_mode_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  sym;
    logic [31:0] code;
    logic [5:0]  len;
  } stim_t;

  typedef struct packed {
    logic [7:0] pbyte;
    logic [3:0] nbits;
    logic       last;
  } packed_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i = huf_pkg::OP_LOAD;
  logic [7:0]  symbol_i = 8'd0;
  logic [31:0] code_bits_i = 32'd0;
  logic [5:0]  code_length_i = 6'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  packed_byte_o;
  logic [3:0]  valid_bits_o;
  logic        last_o;

  huffman_code_bit_packer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .symbol_i      (symbol_i),
    .code_bits_i   (code_bits_i),
    .code_length_i (code_length_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .packed_byte_o (packed_byte_o),
    .valid_bits_o  (valid_bits_o),
    .last_o        (last_o)
  );

  // predictor state: code table, pending bits and counters
  logic [5:0]   len_tbl [huf_pkg::NumSymbols];
  logic [31:0]  code_tbl [huf_pkg::NumSymbols];
  logic [6:0]   pend_bits = 7'd0;
  logic [2:0]   pend_cnt = 3'd0;
  packed_byte_t expected_bytes [$];
  stim_t        item_q [$];
  stim_t        cur_item;
  idle_mode_e   idle_mode = IDLE_TX_LIGHT;
  int           err_cnt = 0;
  int           n_load = 0;
  int           n_encode = 0;
  int           n_flush = 0;
  int           n_other = 0;
  int           n_checked = 0;
  int           n_partial = 0;
  int           idle_cycles = 0;
  int           hold_left = 0;
  bit           hold_done = 1'b0;
  // symbols the stimulus has loaded so far
  logic [7:0]   loaded_syms [$];

  // clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
    err_cnt++;
  endtask

  // apply one accepted transaction to the predictor and queue the bytes it yields
  task automatic pack_predict(input stim_t it);
    int           cap_len;
    int           total;
    int           nbytes;
    logic [63:0]  mask;
    logic [38:0]  acc;
    packed_byte_t res;
    case (it.op)
      huf_pkg::OP_LOAD: begin
        n_load++;
        cap_len = (int'(it.len) > huf_pkg::CodeCap) ? huf_pkg::CodeCap : int'(it.len);
        mask = (64'd1 << cap_len) - 64'd1;
        code_tbl[it.sym] = it.code & mask[31:0];
        len_tbl[it.sym] = cap_len[5:0];
      end
      huf_pkg::OP_ENCODE: begin
        n_encode++;
        if (len_tbl[it.sym] != 6'd0) begin
          acc = ({32'd0, pend_bits} << len_tbl[it.sym]) | {7'd0, code_tbl[it.sym]};
          total = int'(pend_cnt) + int'(len_tbl[it.sym]);
          nbytes = total / 8;
          for (int k = 0; k < nbytes; k++) begin
            total -= 8;
            res.pbyte = 8'(acc >> total);
            res.nbits = 4'd8;
            res.last = (k == nbytes - 1);
            expected_bytes.push_back(res);
          end
          mask = (64'd1 << total) - 64'd1;
          pend_bits = acc[6:0] & mask[6:0];
          pend_cnt = total[2:0];
        end
      end
      huf_pkg::OP_FLUSH: begin
        n_flush++;
        if (pend_cnt != 3'd0) begin
          res.pbyte = {1'b0, pend_bits} << (4'd8 - {1'b0, pend_cnt});
          res.nbits = {1'b0, pend_cnt};
          res.last = 1'b1;
          expected_bytes.push_back(res);
          n_partial++;
          pend_bits = 7'd0;
          pend_cnt = 3'd0;
        end
      end
      default: n_other++;
    endcase
  endtask

  function automatic bit tx_gap();
    case (idle_mode)
      IDLE_TX_LIGHT: return $urandom_range(99) < 19;
      IDLE_TX_HEAVY: return $urandom_range(99) < 60;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit rx_gap();
    case (idle_mode)
      IDLE_TX_LIGHT: return $urandom_range(99) < 60;
      IDLE_TX_HEAVY: return $urandom_range(99) < 19;
      default: return 1'b0;
    endcase
  endfunction

  // input driver: presents queued items, predicts on each accepted transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        pack_predict(cur_item);
      end
      if (!in_valid_i || in_ready_o) begin
        if (item_q.size() != 0 && !tx_gap()) begin
          cur_item = item_q.pop_front();
          in_valid_i <= 1'b1;
          operation_i <= cur_item.op;
          symbol_i <= cur_item.sym;
          code_bits_i <= cur_item.code;
          code_length_i <= cur_item.len;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output ready: random stalls, plus one long hold-off once idling stops
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (idle_mode == IDLE_NONE && !hold_done) begin
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !rx_gap();
      end
    end
  end

  // output monitor: compare each byte with the oldest expectation
  always @(posedge clk_i) begin
    packed_byte_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("byte with none expected", packed_byte_o, 0);
      end else begin
        want = expected_bytes.pop_front();
        n_checked++;
        if (packed_byte_o !== want.pbyte) begin
          report_mismatch("packed_byte", packed_byte_o, want.pbyte);
        end
        if (valid_bits_o !== want.nbits) begin
          report_mismatch("valid_bits", valid_bits_o, want.nbits);
        end
        if (last_o !== want.last) begin
          report_mismatch("last", last_o, want.last);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic add_item(input logic [1:0] op, input logic [7:0] sym,
                          input logic [31:0] code, input logic [5:0] len);
    stim_t it;
    it.op = op;
    it.sym = sym;
    it.code = code;
    it.len = len;
    item_q.push_back(it);
    if (op == huf_pkg::OP_LOAD) begin
      loaded_syms.push_back(sym);
    end
  endtask

  // random mix: mostly encodes of loaded symbols, some loads, flushes and noise
  task automatic add_random_items(input int count);
    int          pick;
    int          lsel;
    logic [5:0]  len;
    logic [7:0]  sym;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 15 || loaded_syms.size() == 0) begin
        lsel = $urandom_range(99);
        if (lsel < 65) len = 6'($urandom_range(9, 1));
        else if (lsel < 88) len = 6'($urandom_range(32, 10));
        else if (lsel < 95) len = 6'($urandom_range(63, 33));
        else len = 6'd0;
        add_item(huf_pkg::OP_LOAD, 8'($urandom_range(255)), $urandom, len);
      end else if (pick < 85) begin
        if ($urandom_range(99) < 85) begin
          sym = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
        end else begin
          sym = 8'($urandom_range(255));
        end
        add_item(huf_pkg::OP_ENCODE, sym, $urandom, 6'($urandom_range(63)));
      end else if (pick < 95) begin
        add_item(huf_pkg::OP_FLUSH, 8'($urandom_range(255)), $urandom,
                 6'($urandom_range(63)));
      end else begin
        add_item(OpUndef, 8'($urandom_range(255)), $urandom, 6'($urandom_range(63)));
      end
    end
  endtask

  task automatic wait_drained();
    while (item_q.size() != 0 || in_valid_i || expected_bytes.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // stimulus sequence
  initial begin
    for (int i = 0; i < huf_pkg::NumSymbols; i++) begin
      len_tbl[i] = 6'd0;
      code_tbl[i] = 32'd0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty flush, unloaded symbol, undefined op, table corner cases
    add_item(huf_pkg::OP_FLUSH, 8'h00, 32'h0, 6'd0);
    add_item(huf_pkg::OP_ENCODE, 8'hA5, 32'hFFFF_FFFF, 6'd63);
    add_item(OpUndef, 8'hFF, 32'hFFFF_FFFF, 6'd63);
    add_item(huf_pkg::OP_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32);
    add_item(huf_pkg::OP_LOAD, 8'hFF, 32'h0000_0000, 6'd1);
    add_item(huf_pkg::OP_LOAD, 8'h3C, 32'hFFFF_FFFF, 6'd3);
    add_item(huf_pkg::OP_LOAD, 8'h81, 32'hDEAD_BEEF, 6'd63);
    add_item(huf_pkg::OP_LOAD, 8'h42, 32'h0000_0001, 6'd33);
    add_item(huf_pkg::OP_LOAD, 8'h10, 32'h0000_0005, 6'd0);
    add_item(huf_pkg::OP_LOAD, 8'h20, 32'h0000_00A5, 6'd8);
    add_item(huf_pkg::OP_ENCODE, 8'h10, 32'h0, 6'd0);
    add_item(huf_pkg::OP_ENCODE, 8'hFF, 32'h0, 6'd0);
    add_item(huf_pkg::OP_FLUSH, 8'h00, 32'h0, 6'd0);
    add_item(huf_pkg::OP_ENCODE, 8'h00, 32'h0, 6'd0);
    add_item(huf_pkg::OP_ENCODE, 8'hFF, 32'h0, 6'd0);
    add_item(huf_pkg::OP_ENCODE, 8'h81, 32'h0, 6'd0);
    add_item(huf_pkg::OP_ENCODE, 8'h3C, 32'h0, 6'd0);
    add_item(huf_pkg::OP_ENCODE, 8'h42, 32'h0, 6'd0);
    add_item(huf_pkg::OP_ENCODE, 8'h3C, 32'h0, 6'd0);
    add_item(huf_pkg::OP_FLUSH, 8'h00, 32'h0, 6'd0);
    add_item(huf_pkg::OP_ENCODE, 8'h20, 32'h0, 6'd0);
    add_item(huf_pkg::OP_ENCODE, 8'h3C, 32'h0, 6'd0);
    add_item(huf_pkg::OP_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'd63);
    add_item(OpUndef, 8'h00, 32'h0, 6'd0);
    add_random_items(130);
    wait_drained();

    // sender mostly idle, receiver mostly ready
    idle_mode = IDLE_TX_HEAVY;
    add_random_items(150);
    wait_drained();

    // no idling, with one long output hold-off at the start
    idle_mode = IDLE_NONE;
    add_random_items(150);
    wait_drained();

    repeat (TailCycles) @(negedge clk_i);
    $display("covered %0d loads, %0d encodes, %0d flushes, %0d undefined operations",
             n_load, n_encode, n_flush, n_other);
    $display("checked %0d output bytes, %0d of them flushed partial bytes",
             n_checked, n_partial);
    if (err_cnt == 0 && expected_bytes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== huffman_code_bit_packer.f =====
hw/rtl/huf_pkg.sv
hw/rtl/huf_ram.sv
hw/rtl/huffman_code_bit_packer.sv
tb/sv/testbench.sv
